FILE: design/ptwe_pkg.sv
// Shared types and codes of the point time window extractor.
`default_nettype none
package ptwe_pkg;

  localparam int COUNT_BITS = 32;

  localparam logic [1:0] ROLE_ABS = 2'd1;
  localparam logic [1:0] ROLE_OFS = 2'd2;

  localparam logic [2:0] VT_F64 = 3'd0;
  localparam logic [2:0] VT_F32 = 3'd1;
  localparam logic [2:0] VT_U32 = 3'd2;
  localparam logic [2:0] VT_I32 = 3'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_ROLE   = 3'd1;
  localparam logic [2:0] ST_ABS_F32    = 3'd2;
  localparam logic [2:0] ST_BAD_STRIDE = 3'd3;
  localparam logic [2:0] ST_BAD_TYPE   = 3'd4;
  localparam logic [2:0] ST_PAST       = 3'd5;
  localparam logic [2:0] ST_NO_TIMES   = 3'd6;
  localparam logic [2:0] ST_BAD_WIN    = 3'd7;

  localparam logic [2:0] CFG_ROLE   = 3'd0;
  localparam logic [2:0] CFG_TYPE   = 3'd1;
  localparam logic [2:0] CFG_STAMP  = 3'd2;
  localparam logic [2:0] CFG_OFFSET = 3'd3;
  localparam logic [2:0] CFG_STRIDE = 3'd4;

  // One classified point handed from the front end to the back end.
  typedef struct packed {
    logic        ok;
    logic [63:0] ns;
    logic        last;
    logic [2:0]  status;
    logic [1:0]  unit_code;
  } ptwe_item_t;

endpackage
`default_nettype wire

FILE: design/ptwe_front.sv
// Front end: decodes the raw time word into nanoseconds and classifies it.
`default_nettype none
module ptwe_front
  import ptwe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] field_bits,
  input  wire logic        last,
  input  wire logic [1:0]  role_code,
  input  wire logic [2:0]  value_type,
  input  wire logic [63:0] stamp_ns,
  input  wire logic [15:0] byte_offset,
  input  wire logic [15:0] point_stride,
  output ptwe_item_t       item,
  output logic             item_valid,
  input  wire logic        item_ready
);

  localparam logic [29:0] TEN9 = 30'd1000000000;

  // Per-point fields that ride along the arithmetic stages.
  typedef struct packed {
    logic        last;
    logic        is_float;
    logic        int_ok;
    logic [63:0] int_ns;
    logic        sign;
    logic        nan;
    logic        offset;
    logic [63:0] stamp;
    logic [2:0]  status;
    logic [1:0]  unit;
  } side_t;

  // Stage 1 registers: unpacked double and the integer path.
  logic        s1_valid;
  side_t       s1_side;
  logic [10:0] s1_exp;
  logic [52:0] s1_mant;

  // Stage 2 registers: partial products of the mantissa halves by 1e9.
  logic        s2_valid;
  side_t       s2_side;
  logic [10:0] s2_exp;
  logic [56:0] s2_p_hi;
  logic [55:0] s2_p_lo;

  // Stage 3 registers: exact product mant * 1e9 (83 bits) and exponent.
  logic        s3_valid;
  side_t       s3_side;
  logic [10:0] s3_exp;
  logic [82:0] s3_prod;

  // Stage 4 registers: product rounded to 53 bits and its binary scale.
  logic               s4_valid;
  side_t              s4_side;
  logic [52:0]        s4_rm;
  logic signed [13:0] s4_sh;
  logic               s4_zero;

  // Stage 5 output register.
  logic        s5_valid;
  ptwe_item_t  s5_item;

  logic adv5, adv4, adv3, adv2, adv1;
  assign adv5     = !s5_valid || item_ready;
  assign adv4     = !s4_valid || adv5;
  assign adv3     = !s3_valid || adv4;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;
  assign item       = s5_item;
  assign item_valid = s5_valid;

  // Configuration checks and unit code for this item.
  logic [2:0]  cfg_st;
  logic [1:0]  unit_c;
  logic [16:0] need;
  always_comb begin
    need = {1'b0, byte_offset} + ((value_type == VT_F64) ? 17'd8 : 17'd4);
    if (role_code != ROLE_ABS && role_code != ROLE_OFS) cfg_st = ST_BAD_ROLE;
    else if (role_code == ROLE_ABS && value_type == VT_F32) cfg_st = ST_ABS_F32;
    else if (point_stride == 16'd0) cfg_st = ST_BAD_STRIDE;
    else if (value_type > VT_I32) cfg_st = ST_BAD_TYPE;
    else if (need > {1'b0, point_stride}) cfg_st = ST_PAST;
    else cfg_st = ST_OK;
    if (role_code == ROLE_ABS) unit_c = 2'd1;
    else if (role_code == ROLE_OFS && value_type <= VT_F32) unit_c = 2'd3;
    else if (role_code == ROLE_OFS && value_type <= VT_I32) unit_c = 2'd2;
    else unit_c = 2'd0;
  end

  // Unpack to a common double form; float32 widens exactly.
  logic        d_sign;
  logic [10:0] d_exp;
  logic [52:0] d_mant;
  logic        d_nan;
  logic [4:0]  lz;
  logic [22:0] f_frac;
  logic [22:0] f_norm;
  always_comb begin
    f_frac = field_bits[22:0];
    lz = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (f_frac[i]) lz = 5'(22 - i);
    end
    f_norm = f_frac << (lz + 5'd1);
    d_sign = 1'b0; d_exp = 11'd0; d_mant = 53'd0; d_nan = 1'b0;
    if (value_type == VT_F64) begin
      d_sign = field_bits[63];
      d_exp  = field_bits[62:52];
      d_nan  = (field_bits[62:52] == 11'h7FF);
      d_mant = {(field_bits[62:52] != 11'd0), field_bits[51:0]};
      if (field_bits[62:52] == 11'd0) d_exp = 11'd1;
    end else begin
      d_sign = field_bits[31];
      d_nan  = (field_bits[30:23] == 8'hFF);
      if (field_bits[30:23] == 8'd0) begin
        if (f_frac == 23'd0) begin
          d_exp = 11'd1; d_mant = 53'd0;
        end else begin
          d_exp  = 11'(11'd1023 - 11'd127 - 11'(lz));
          d_mant = {1'b1, f_norm, 29'd0};
        end
      end else begin
        d_exp  = 11'(11'(field_bits[30:23]) + 11'd896);
        d_mant = {1'b1, f_frac, 29'd0};
      end
    end
  end

  side_t side_in;
  always_comb begin
    side_in.last     = last;
    side_in.is_float = (value_type <= VT_F32);
    side_in.int_ok   = (role_code == ROLE_OFS) &&
                       (value_type == VT_U32 || value_type == VT_I32);
    side_in.int_ns   = (value_type == VT_I32) ? {{32{field_bits[31]}}, field_bits[31:0]}
                                              : {32'd0, field_bits[31:0]};
    side_in.sign     = d_sign;
    side_in.nan      = d_nan;
    side_in.offset   = (role_code == ROLE_OFS);
    side_in.stamp    = stamp_ns;
    side_in.status   = cfg_st;
    side_in.unit     = unit_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= in_valid;
    end
    if (adv1) begin
      s1_side <= side_in;
      s1_exp  <= d_exp;
      s1_mant <= d_mant;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
    if (adv2) begin
      s2_side <= s1_side;
      s2_exp  <= s1_exp;
      s2_p_hi <= 57'(s1_mant[52:26]) * 57'(TEN9);
      s2_p_lo <= 56'(s1_mant[25:0]) * 56'(TEN9);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
    if (adv3) begin
      s3_side <= s2_side;
      s3_exp  <= s2_exp;
      s3_prod <= {s2_p_hi, 26'd0} + 83'(s2_p_lo);
    end
  end

  // Round the exact product to double (nearest even).
  // Value = prod * 2^(exp-1075). Normalize prod to its top bit, keep 53.
  logic [6:0]  msb;
  logic [82:0] pn;
  logic [53:0] rm;
  logic        sticky;
  logic [12:0] e2;
  logic signed [13:0] sh;
  always_comb begin
    msb = 7'd0;
    for (int i = 0; i < 83; i++) begin
      if (s3_prod[i]) msb = 7'(i);
    end
    pn = s3_prod << (7'd82 - msb);
    sticky = |pn[28:0];
    rm = {1'b0, pn[82:30]};
    if (pn[29] && (sticky || pn[30])) rm = rm + 54'd1;
    // e2: binary exponent of the value's leading bit, biased by 1075.
    e2 = 13'(s3_exp) + 13'(msb);
    if (rm[53]) begin
      rm = rm >> 1;
      e2 = e2 + 13'd1;
    end
    // value = rm * 2^(e2 - 1075 - 52)
    sh = 14'(e2) - 14'sd1127;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv4) begin
      s4_valid <= s3_valid;
    end
    if (adv4) begin
      s4_side <= s3_side;
      s4_rm   <= rm[52:0];
      s4_sh   <= sh;
      s4_zero <= (s3_prod == 83'd0);
    end
  end

  // Truncate toward zero and check the int64 range.
  logic [63:0]  mag;
  logic         f_ok;
  logic [127:0] wide;
  logic [63:0]  ns_val;
  always_comb begin
    mag = 64'd0;
    f_ok = 1'b1;
    wide = 128'd0;
    if (s4_zero) begin
      mag = 64'd0;
    end else if (s4_sh >= 14'sd0) begin
      if (s4_sh > 14'sd11) begin
        f_ok = 1'b0;
      end else begin
        wide = 128'(s4_rm) << s4_sh[3:0];
        mag  = wide[63:0];
        if (mag[63] && !(s4_side.sign && mag == 64'h8000000000000000)) f_ok = 1'b0;
      end
    end else if (s4_sh > -14'sd54) begin
      mag = 64'(s4_rm >> 6'(-s4_sh));
    end
    if (s4_side.nan) f_ok = 1'b0;
    ns_val = s4_side.sign ? 64'(-mag) : mag;
    if (!s4_side.is_float) ns_val = s4_side.int_ns;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv5) begin
      s5_valid <= s4_valid;
    end
    if (adv5) begin
      s5_item.ok        <= (s4_side.status != ST_BAD_ROLE) &&
                           (s4_side.is_float ? f_ok : s4_side.int_ok);
      s5_item.ns        <= s4_side.offset ? ns_val + s4_side.stamp : ns_val;
      s5_item.last      <= s4_side.last;
      s5_item.status    <= s4_side.status;
      s5_item.unit_code <= s4_side.unit;
    end
  end

endmodule
`default_nettype wire

FILE: design/ptwe_fifo.sv
// Short queue of classified points between the front and back ends.
`default_nettype none
module ptwe_fifo
  import ptwe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  ptwe_item_t wr_item,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  output ptwe_item_t rd_item,
  output logic       rd_valid,
  input  wire logic  rd_ready
);

  ptwe_item_t slots [2];
  logic       wp, rp;
  logic [1:0] fill;
  logic       do_wr, do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_item  = slots[rp];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= 2'd0;
    end else begin
      if (do_wr) wp <= !wp;
      if (do_rd) rp <= !rp;
      fill <= fill + 2'(do_wr) - 2'(do_rd);
    end
    if (do_wr) slots[wp] <= wr_item;
  end

endmodule
`default_nettype wire

FILE: design/ptwe_back.sv
// Back end: running min, max and counts, and the result register.
`default_nettype none
module ptwe_back
  import ptwe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  ptwe_item_t item,
  input  wire logic  item_valid,
  output logic       item_ready,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [2:0]  status,
  output logic [1:0]  unit_code,
  output logic [63:0] window_start_ns,
  output logic [63:0] window_end_ns,
  output logic [31:0] points_total,
  output logic [31:0] points_used,
  output logic        window_valid
);

  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic signed [63:0]    min_time, max_time;
  logic                  seen_valid;
  logic [COUNT_BITS-1:0] total_count, used_count;
  logic signed [63:0]    min_next, max_next;
  logic [COUNT_BITS-1:0] total_next, used_next;
  logic                  take;

  assign item_ready = !out_valid || out_ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    total_next = (total_count != CMAX) ? total_count + 1'b1 : total_count;
    used_next  = used_count;
    min_next   = min_time;
    max_next   = max_time;
    if (item.ok) begin
      if (used_count != CMAX) used_next = used_count + 1'b1;
      if (!seen_valid || $signed(item.ns) < min_time) min_next = item.ns;
      if (!seen_valid || $signed(item.ns) > max_time) max_next = item.ns;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_valid  <= 1'b0;
      total_count <= '0;
      used_count  <= '0;
      min_time    <= '0;
      max_time    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (take && item.last) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (take) begin
        if (item.last) begin
          seen_valid  <= 1'b0;
          total_count <= '0;
          used_count  <= '0;
          min_time    <= '0;
          max_time    <= '0;
        end else begin
          seen_valid  <= seen_valid || item.ok;
          total_count <= total_next;
          used_count  <= used_next;
          min_time    <= min_next;
          max_time    <= max_next;
        end
      end
    end
    if (take && item.last) begin
      unit_code    <= item.unit_code;
      points_total <= 32'(total_next);
      if (item.status != ST_OK) begin
        status          <= item.status;
        points_used     <= 32'd0;
        window_start_ns <= 64'd0;
        window_end_ns   <= 64'd0;
        window_valid    <= 1'b0;
      end else if (!(seen_valid || item.ok)) begin
        status          <= ST_NO_TIMES;
        points_used     <= 32'(used_next);
        window_start_ns <= 64'd0;
        window_end_ns   <= 64'd0;
        window_valid    <= 1'b0;
      end else if (max_next < min_next) begin
        status          <= ST_BAD_WIN;
        points_used     <= 32'(used_next);
        window_start_ns <= min_next;
        window_end_ns   <= max_next;
        window_valid    <= 1'b0;
      end else begin
        status          <= ST_OK;
        points_used     <= 32'(used_next);
        window_start_ns <= min_next;
        window_end_ns   <= max_next;
        window_valid    <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/point_time_window_extractor_top.sv
// Top level of the point time window extractor.
// Usage: configuration is written through cfg_we / cfg_index / cfg_data while
// the block is idle. Register 0 is the time role, 1 the value type, 2 the
// header stamp in nanoseconds, 3 the field offset and 4 the point stride.
// Each input request carries one point's raw time word and a last flag on
// in_valid / in_ready. Only a request marked last produces an output request
// on out_valid / out_ready, carrying status, unit code, window and counts.
// Throughput is one point per cycle unless a result waits on out_ready. The
// front end is a five stage pipeline: unpack, two partial products of the
// mantissa halves by 1e9, their sum, rounding to double, then truncation and
// the stamp add. A two entry queue separates it from the back end, which
// updates min, max and counts and registers the result that out_valid flags.
// When the receiver stalls the result register holds; the queue and front
// pipeline keep taking points until they hold seven, then in_ready drops.
// Reset clears the valid flags (not window_valid) and the accumulators and
// loads register reset values (role, type unsupported; zero stamp and sizes).
`default_nettype none
module point_time_window_extractor_top
  import ptwe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] field_bits,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [1:0]       unit_code,
  output logic [63:0]      window_start_ns,
  output logic [63:0]      window_end_ns,
  output logic [31:0]      points_total,
  output logic [31:0]      points_used,
  output logic             window_valid
);

  // Configuration registers.
  logic [1:0]  role_code;
  logic [2:0]  value_type;
  logic [63:0] stamp_ns;
  logic [15:0] byte_offset;
  logic [15:0] point_stride;

  always_ff @(posedge clk) begin
    if (rst) begin
      role_code    <= 2'd0;
      value_type   <= 3'd4;
      stamp_ns     <= 64'd0;
      byte_offset  <= 16'd0;
      point_stride <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROLE:   role_code    <= cfg_data[1:0];
        CFG_TYPE:   value_type   <= cfg_data[2:0];
        CFG_STAMP:  stamp_ns     <= cfg_data;
        CFG_OFFSET: byte_offset  <= cfg_data[15:0];
        CFG_STRIDE: point_stride <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  ptwe_item_t f_item, q_item;
  logic       f_valid, f_ready, q_valid, q_ready;

  ptwe_front u_front (
    .clk, .rst, .in_valid, .in_ready, .field_bits, .last,
    .role_code, .value_type, .stamp_ns, .byte_offset, .point_stride,
    .item(f_item), .item_valid(f_valid), .item_ready(f_ready)
  );

  ptwe_fifo u_fifo (
    .clk, .rst,
    .wr_item(f_item), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_item(q_item), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  ptwe_back u_back (
    .clk, .rst, .item(q_item), .item_valid(q_valid), .item_ready(q_ready),
    .out_valid, .out_ready, .status, .unit_code, .window_start_ns,
    .window_end_ns, .points_total, .points_used, .window_valid
  );

endmodule
`default_nettype wire
